@@ sv/ppu_sar_pkg.sv @@
// Shared types and codes for the scroll and address register block.
// No dependencies; imported by ppu_sar_core, ppu_scroll_address_registers and tb_top.
package ppu_sar_pkg;

  typedef enum logic [2:0] {
    KIND_REG_WRITE = 3'd0,
    KIND_REG_READ  = 3'd1,
    KIND_COARSE_X  = 3'd2,
    KIND_Y_INC     = 3'd3,
    KIND_COPY_H    = 3'd4,
    KIND_COPY_V    = 3'd5
  } kind_e;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  localparam logic [15:0] COPY_H_KEEP = 16'hfbe0;
  localparam logic [15:0] COPY_H_TAKE = 16'h041f;
  localparam logic [15:0] COPY_V_KEEP = 16'h841f;
  localparam logic [15:0] COPY_V_TAKE = 16'h7be0;
  localparam logic [4:0]  LAST_ROW    = 5'd29;
  localparam logic [7:0]  RENDER_BITS = 8'h18;
  localparam logic [5:0]  PALETTE_PAGE = 6'h3f;

  typedef struct packed {
    logic [14:0] temp_address;
    logic [15:0] current_address;
    logic [2:0]  fine_x;
    logic        second_write;
    logic [7:0]  control;
    logic [7:0]  mask;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  register_index;
    logic [7:0]  write_data;
    logic        in_vblank;
  } item_t;

  typedef struct packed {
    logic [15:0] vram_address;
    logic [2:0]  fine_x;
    logic        write_toggle;
    logic        access_valid;
    logic        access_is_write;
    logic [13:0] access_address;
    logic [7:0]  access_data;
    logic        rendering_on;
  } result_t;

endpackage

@@ sv/ppu_sar_core.sv @@
// Combinational step logic: next scroll state and result for one event.
// Depends on ppu_sar_pkg.
module ppu_sar_core (
  input  ppu_sar_pkg::state_t  state_i,
  input  ppu_sar_pkg::item_t   item_i,
  output ppu_sar_pkg::state_t  state_o,
  output ppu_sar_pkg::result_t result_o
);
  import ppu_sar_pkg::*;

  function automatic logic [15:0] coarse_x_inc(input logic [15:0] v);
    logic [15:0] r;
    if (v[4:0] == 5'h1f) begin
      r = {v[15:11], ~v[10], v[9:5], 5'd0};
    end else begin
      r = v + 16'd1;
    end
    return r;
  endfunction

  function automatic logic [15:0] y_inc(input logic [15:0] v);
    logic [15:0] r;
    logic [4:0]  cy;
    logic        nt;
    if (v[14:12] != 3'h7) begin
      r = v + 16'h1000;
    end else begin
      nt = v[11];
      if (v[9:5] == LAST_ROW) begin
        cy = 5'd0;
        nt = ~v[11];
      end else if (v[9:5] == 5'h1f) begin
        cy = 5'd0;
      end else begin
        cy = v[9:5] + 5'd1;
      end
      r = {v[15], 3'd0, nt, v[10], cy, v[4:0]};
    end
    return r;
  endfunction

  logic        render;
  logic [15:0] v;
  logic [14:0] t;
  logic [7:0]  d;
  logic [15:0] port_step;

  assign render    = (state_i.mask & RENDER_BITS) != 8'd0;
  assign v         = state_i.current_address;
  assign t         = state_i.temp_address;
  assign d         = item_i.write_data;
  assign port_step = state_i.control[2] ? 16'd32 : 16'd1;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (item_i.kind)
      KIND_REG_WRITE: begin
        unique case (item_i.register_index)
          REG_CTRL: begin
            state_o.control            = d;
            state_o.temp_address[11:10] = d[1:0];
          end
          REG_MASK: state_o.mask = d;
          REG_SCROLL: begin
            if (!state_i.second_write) begin
              state_o.temp_address[4:0] = d[7:3];
              state_o.fine_x            = d[2:0];
              state_o.second_write      = 1'b1;
            end else begin
              state_o.temp_address[9:5]   = d[7:3];
              state_o.temp_address[14:12] = d[2:0];
              state_o.second_write        = 1'b0;
            end
          end
          REG_ADDR: begin
            if (!state_i.second_write) begin
              state_o.temp_address[14]   = 1'b0;
              state_o.temp_address[13:8] = d[5:0];
              state_o.second_write       = 1'b1;
            end else begin
              state_o.temp_address    = {t[14:8], d};
              state_o.current_address = {1'b0, t[14:8], d};
              state_o.second_write    = 1'b0;
            end
          end
          REG_DATA: begin
            if (item_i.in_vblank || !render) begin
              result_o.access_valid    = 1'b1;
              result_o.access_is_write = 1'b1;
              result_o.access_address  = v[13:0];
              result_o.access_data     = (v[13:8] == PALETTE_PAGE) ? {2'b00, d[5:0]} : d;
              state_o.current_address  = v + port_step;
            end else begin
              // Writing the data port mid-frame bumps both scroll counters.
              state_o.current_address = coarse_x_inc(y_inc(v));
            end
          end
          default: ;
        endcase
      end
      KIND_REG_READ: begin
        if (item_i.register_index == REG_STATUS) begin
          state_o.second_write = 1'b0;
        end else if (item_i.register_index == REG_DATA) begin
          result_o.access_valid   = 1'b1;
          result_o.access_address = v[13:0];
          state_o.current_address = v + port_step;
        end
      end
      KIND_COARSE_X: if (render) state_o.current_address = coarse_x_inc(v);
      KIND_Y_INC:    if (render) state_o.current_address = y_inc(v);
      KIND_COPY_H: begin
        if (render) begin
          state_o.current_address = (v & COPY_H_KEEP) | ({1'b0, t} & COPY_H_TAKE);
        end
      end
      KIND_COPY_V: begin
        if (render) begin
          state_o.current_address = (v & COPY_V_KEEP) | ({1'b0, t} & COPY_V_TAKE);
        end
      end
      default: ;
    endcase
    result_o.vram_address = state_o.current_address;
    result_o.fine_x       = state_o.fine_x;
    result_o.write_toggle = state_o.second_write;
    result_o.rendering_on = (state_o.mask & RENDER_BITS) != 8'd0;
  end

endmodule

@@ sv/ppu_scroll_address_registers.sv @@
// A beat accepted on the input side passes through the input register, then the result
// register. Throughput: one beat per cycle while the result side does not stall.
// The event is evaluated from the input register against the state registers
// and the state updates as the beat moves into the result register.
// Reset clears the address, scroll, toggle, control and mask state and both
// valid flags. Uses ppu_sar_pkg and ppu_sar_core.
module ppu_scroll_address_registers (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // register_index, write_data, in_vblank, zero pad
  input  logic [2:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // vram_address, fine_x, write_toggle, access_valid,
                                     // access_is_write, access_address, access_data,
                                     // rendering_on, zero pad
);
  import ppu_sar_pkg::*;

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  state_t  state_q, state_d;
  result_t res_d;
  logic    out_free, advance, in_fire;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  ppu_sar_core u_core (
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (out_free) out_valid_q <= in_valid_q;
      if (advance) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q.kind           <= kind_e'(s_axis_tuser);
      in_item_q.register_index <= s_axis_tdata[2:0];
      in_item_q.write_data     <= s_axis_tdata[10:3];
      in_item_q.in_vblank      <= s_axis_tdata[11];
    end
    if (advance) out_res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0,
                          out_res_q.rendering_on,
                          out_res_q.access_data,
                          out_res_q.access_address,
                          out_res_q.access_is_write,
                          out_res_q.access_valid,
                          out_res_q.write_toggle,
                          out_res_q.fine_x,
                          out_res_q.vram_address};

`ifndef SYNTHESIS
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without an event");

  a_access_from_data_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d.access_valid) |->
      (in_item_q.register_index == REG_DATA &&
       (in_item_q.kind == KIND_REG_WRITE || in_item_q.kind == KIND_REG_READ)))
    else $error("data access from an event other than the data port");

  a_status_clears_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_item_q.kind == KIND_REG_READ &&
     in_item_q.register_index == REG_STATUS) |=> !state_q.second_write)
    else $error("status read left the write toggle set");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_res_q.vram_address == state_q.current_address &&
                 out_res_q.write_toggle == state_q.second_write))
    else $error("result beat disagrees with the updated state");
`endif

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for ppu_scroll_address_registers: a directed table, then random
// scroll/address/data-port traffic, each result beat compared with a local predictor
// or a hand-computed result. Depends on ppu_sar_pkg and the block's RTL only.
module tb_top;
  import ppu_sar_pkg::*;

  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // register_index, write_data, in_vblank, zero pad
  logic [2:0]  s_axis_tuser;   // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;   // vram_address, fine_x, write_toggle, access_valid,
                               // access_is_write, access_address, access_data,
                               // rendering_on, zero pad

  ppu_scroll_address_registers i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Predictor state: temporary address, current address, fine X, toggle, control, mask.
  logic [14:0] tmp_addr = '0;
  logic [15:0] vram_q = '0;
  logic [2:0]  fine_x_q = '0;
  logic        toggle_q = 1'b0;
  logic [7:0]  ctrl_q = '0;
  logic [7:0]  mask_q = '0;

  result_t due_results[$];
  int      mismatches = 0;
  int      beats_in = 0;
  int      beats_out = 0;
  int      cycle_count = 0;
  bit      drv_fixed;
  result_t drv_want;
  int      hold_left = 0;
  bit      hold_done = 1'b0;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  idx;
    logic [7:0]  data;
    logic        vbl;
    bit          fixed;
    result_t     want;
  } row_t;

  // Rows with fixed set carry a hand-computed result; the rest use the predictor.
  row_t script [0:27] = '{
    '{KIND_REG_READ,  REG_DATA,     8'h00, 1'b1, 1'b1,
      '{16'h0001, 3'd0, 1'b0, 1'b1, 1'b0, 14'h0000, 8'h00, 1'b0}},
    '{KIND_REG_WRITE, REG_CTRL,     8'hff, 1'b1, 1'b1,
      '{16'h0001, 3'd0, 1'b0, 1'b0, 1'b0, 14'h0000, 8'h00, 1'b0}},
    '{KIND_REG_WRITE, REG_SCROLL,   8'hff, 1'b1, 1'b1,
      '{16'h0001, 3'd7, 1'b1, 1'b0, 1'b0, 14'h0000, 8'h00, 1'b0}},
    '{KIND_REG_WRITE, REG_SCROLL,   8'hff, 1'b1, 1'b0, '0},
    '{KIND_REG_WRITE, REG_ADDR,     8'hff, 1'b1, 1'b0, '0},
    '{KIND_REG_WRITE, REG_ADDR,     8'hff, 1'b1, 1'b1,
      '{16'h3fff, 3'd7, 1'b0, 1'b0, 1'b0, 14'h0000, 8'h00, 1'b0}},
    '{KIND_REG_WRITE, REG_DATA,     8'hff, 1'b1, 1'b1,
      '{16'h401f, 3'd7, 1'b0, 1'b1, 1'b1, 14'h3fff, 8'h3f, 1'b0}},
    '{KIND_REG_WRITE, REG_DATA,     8'ha5, 1'b0, 1'b1,
      '{16'h403f, 3'd7, 1'b0, 1'b1, 1'b1, 14'h001f, 8'ha5, 1'b0}},
    '{KIND_REG_WRITE, REG_ADDR,     8'h00, 1'b0, 1'b0, '0},
    '{KIND_REG_READ,  REG_STATUS,   8'h00, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, REG_OAM_DATA, 8'haa, 1'b0, 1'b0, '0},
    '{KIND_COARSE_X,  REG_CTRL,     8'h00, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, REG_MASK,     8'h18, 1'b0, 1'b1,
      '{16'h403f, 3'd7, 1'b0, 1'b0, 1'b0, 14'h0000, 8'h00, 1'b1}},
    '{KIND_REG_WRITE, REG_SCROLL,   8'hef, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, REG_SCROLL,   8'hef, 1'b0, 1'b0, '0},
    '{KIND_COPY_V,    REG_CTRL,     8'h00, 1'b0, 1'b0, '0},
    '{KIND_Y_INC,     REG_CTRL,     8'h00, 1'b0, 1'b0, '0},
    '{KIND_COARSE_X,  REG_CTRL,     8'h00, 1'b0, 1'b0, '0},
    '{KIND_COPY_H,    REG_CTRL,     8'h00, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, REG_DATA,     8'h3c, 1'b0, 1'b0, '0},
    '{KIND_REG_READ,  REG_DATA,     8'h00, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, REG_MASK,     8'h10, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, REG_SCROLL,   8'hff, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, REG_SCROLL,   8'hff, 1'b0, 1'b0, '0},
    '{KIND_COPY_V,    REG_CTRL,     8'h00, 1'b0, 1'b0, '0},
    '{KIND_Y_INC,     REG_CTRL,     8'h00, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, REG_MASK,     8'h00, 1'b0, 1'b0, '0},
    '{KIND_Y_INC,     REG_CTRL,     8'h00, 1'b0, 1'b0, '0}
  };

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic bit render_on();
    return (mask_q & RENDER_BITS) != 8'h00;
  endfunction

  function automatic void bump_coarse_x();
    if (!render_on()) return;
    if (vram_q[4:0] == 5'h1f) begin
      vram_q[4:0] = 5'h00;
      vram_q[10]  = ~vram_q[10];
    end else begin
      vram_q = vram_q + 16'd1;
    end
  endfunction

  function automatic void bump_fine_y();
    logic [4:0] row;
    if (!render_on()) return;
    if (vram_q[14:12] != 3'd7) begin
      vram_q = vram_q + 16'h1000;
    end else begin
      vram_q[14:12] = 3'd0;
      row = vram_q[9:5];
      // Row 29 is the last visible row and flips the vertical nametable; rows 30 and 31 are
      // attribute space: row 30 steps on to row 31, which wraps to row 0 without flipping.
      if (row == LAST_ROW) begin
        row = 5'd0;
        vram_q[11] = ~vram_q[11];
      end else if (row == 5'h1f) begin
        row = 5'd0;
      end else begin
        row = row + 5'd1;
      end
      vram_q[9:5] = row;
    end
  endfunction

  function automatic void advance_port();
    vram_q = vram_q + (ctrl_q[2] ? 16'd32 : 16'd1);
  endfunction

  function automatic result_t apply_event(input item_t it);
    result_t r;
    r = '0;
    case (it.kind)
      KIND_REG_WRITE: begin
        case (it.register_index)
          REG_CTRL: begin
            ctrl_q = it.write_data;
            tmp_addr[11:10] = it.write_data[1:0];
          end
          REG_MASK: mask_q = it.write_data;
          REG_SCROLL: begin
            if (!toggle_q) begin
              tmp_addr[4:0] = it.write_data[7:3];
              fine_x_q = it.write_data[2:0];
            end else begin
              tmp_addr[9:5] = it.write_data[7:3];
              tmp_addr[14:12] = it.write_data[2:0];
            end
            toggle_q = ~toggle_q;
          end
          REG_ADDR: begin
            if (!toggle_q) begin
              tmp_addr[13:8] = it.write_data[5:0];
              tmp_addr[14] = 1'b0;
            end else begin
              tmp_addr[7:0] = it.write_data;
              vram_q = {1'b0, tmp_addr};
            end
            toggle_q = ~toggle_q;
          end
          REG_DATA: begin
            if (it.in_vblank || !render_on()) begin
              r.access_valid = 1'b1;
              r.access_is_write = 1'b1;
              r.access_address = vram_q[13:0];
              r.access_data = (vram_q[13:8] == PALETTE_PAGE) ?
                              {2'b00, it.write_data[5:0]} : it.write_data;
              advance_port();
            end else begin
              // A data write while rendering bumps both scroll counters instead.
              bump_fine_y();
              bump_coarse_x();
            end
          end
          default: ;
        endcase
      end
      KIND_REG_READ: begin
        if (it.register_index == REG_STATUS) begin
          toggle_q = 1'b0;
        end else if (it.register_index == REG_DATA) begin
          r.access_valid = 1'b1;
          r.access_address = vram_q[13:0];
          advance_port();
        end
      end
      KIND_COARSE_X: bump_coarse_x();
      KIND_Y_INC:    bump_fine_y();
      KIND_COPY_H: begin
        if (render_on()) vram_q = (vram_q & COPY_H_KEEP) | ({1'b0, tmp_addr} & COPY_H_TAKE);
      end
      KIND_COPY_V: begin
        if (render_on()) vram_q = (vram_q & COPY_V_KEEP) | ({1'b0, tmp_addr} & COPY_V_TAKE);
      end
      default: ;
    endcase
    r.vram_address = vram_q;
    r.fine_x = fine_x_q;
    r.write_toggle = toggle_q;
    r.rendering_on = render_on();
    return r;
  endfunction

  function automatic result_t unpack_beat(input logic [47:0] b);
    result_t r;
    r.vram_address    = b[15:0];
    r.fine_x          = b[18:16];
    r.write_toggle    = b[19];
    r.access_valid    = b[20];
    r.access_is_write = b[21];
    r.access_address  = b[35:22];
    r.access_data     = b[43:36];
    r.rendering_on    = b[44];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch on result beat %0d, %s: got %h, expected %h",
             beats_out, what, got, want);
    mismatches++;
  endtask

  function automatic bit quiet_phase();
    return beats_in >= 800 && beats_in < 1100;
  endfunction

  // Input acceptance feeds the predictor; output acceptance checks the oldest result.
  always @(posedge clk_i) begin
    item_t   it;
    result_t got;
    result_t want;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      it.kind = kind_e'(s_axis_tuser);
      it.register_index = s_axis_tdata[2:0];
      it.write_data = s_axis_tdata[10:3];
      it.in_vblank = s_axis_tdata[11];
      want = apply_event(it);
      due_results.push_back(drv_fixed ? drv_want : want);
      beats_in++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = unpack_beat(m_axis_tdata);
      if (due_results.size() == 0) begin
        report_mismatch("unexpected beat, vram_address", got.vram_address, 16'h0);
      end else begin
        want = due_results.pop_front();
        if (got.vram_address !== want.vram_address)
          report_mismatch("vram_address", got.vram_address, want.vram_address);
        if (got.fine_x !== want.fine_x)
          report_mismatch("fine_x", 16'(got.fine_x), 16'(want.fine_x));
        if (got.write_toggle !== want.write_toggle)
          report_mismatch("write_toggle", 16'(got.write_toggle), 16'(want.write_toggle));
        if (got.access_valid !== want.access_valid)
          report_mismatch("access_valid", 16'(got.access_valid), 16'(want.access_valid));
        if (got.access_is_write !== want.access_is_write)
          report_mismatch("access_is_write", 16'(got.access_is_write),
                          16'(want.access_is_write));
        if (got.access_address !== want.access_address)
          report_mismatch("access_address", 16'(got.access_address),
                          16'(want.access_address));
        if (got.access_data !== want.access_data)
          report_mismatch("access_data", 16'(got.access_data), 16'(want.access_data));
        if (got.rendering_on !== want.rendering_on)
          report_mismatch("rendering_on", 16'(got.rendering_on), 16'(want.rendering_on));
      end
      beats_out++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, due_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off so the block backs up its input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready = 1'b0;
    end else begin
      if (!hold_done && beats_in >= 400) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = quiet_phase() || ($urandom_range(99) >= 7);
      end
    end
  end

  task automatic send_beat(input kind_e kind, input logic [2:0] idx,
                           input logic [7:0] data, input logic vbl,
                           input bit fixed, input result_t want);
    while (!quiet_phase() && $urandom_range(99) < 7) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'b0000, vbl, data, idx};
    s_axis_tuser  = kind;
    drv_fixed     = fixed;
    drv_want      = want;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_random(input kind_e kind, input logic [2:0] idx, input logic [7:0] data);
    send_beat(kind, idx, data, $urandom_range(99) < 30, 1'b0, '0);
  endtask

  initial begin
    int      pick;
    logic [2:0] port;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    drv_fixed = 1'b0;
    drv_want = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[i])
      send_beat(script[i].kind, script[i].idx, script[i].data, script[i].vbl,
                script[i].fixed, script[i].want);

    // Mostly frame-like traffic: scroll and address pairs, data-port bursts and
    // rendering events, with some wholly random beats mixed in.
    while (beats_in < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_random(kind_e'($urandom_range(KIND_COARSE_X, KIND_COPY_V)), 3'($urandom()),
                    8'($urandom()));
      end else if (pick < 62) begin
        if ($urandom_range(3) == 0) send_random(KIND_REG_READ, REG_STATUS, 8'($urandom()));
        port = $urandom_range(1) ? REG_SCROLL : REG_ADDR;
        send_random(KIND_REG_WRITE, port, 8'($urandom()));
        send_random(KIND_REG_WRITE, port, 8'($urandom()));
      end else if (pick < 76) begin
        send_random($urandom_range(1) ? KIND_REG_WRITE : KIND_REG_READ, REG_DATA,
                    8'($urandom()));
      end else if (pick < 85) begin
        send_random(KIND_REG_WRITE, REG_MASK, 8'($urandom()));
      end else if (pick < 90) begin
        send_random(KIND_REG_WRITE, REG_CTRL, 8'($urandom()));
      end else begin
        send_random(kind_e'($urandom_range(KIND_REG_WRITE, KIND_COPY_V)), 3'($urandom()),
                    8'($urandom()));
      end
    end
    s_axis_tvalid = 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
